[rtl/core/gbgcr_pkg.sv]
`default_nettype none

package gbgcr_pkg;

    localparam int PANEL_COLUMNS = 192;
    localparam int PANEL_ROWS    = 64;
    localparam int CHIP_COLUMNS  = 64;
    localparam int CHIP_BITS     = $clog2(CHIP_COLUMNS);

    localparam int GLYPH_BYTES   = 32;
    localparam int GLYPH_AW      = $clog2(GLYPH_BYTES);

    localparam int IN_W          = 40;
    localparam int OUT_W         = 48;
    localparam int OFF_W         = 15;
    localparam int ADDR_W        = 20;

    localparam logic [7:0] LEAD_MIN     = 8'h80;
    localparam logic [7:0] TRAIL_MIN    = 8'h40;
    localparam logic [7:0] R1_LEAD      = 8'hB0;
    localparam logic [7:0] R1_TRAIL     = 8'hA1;
    localparam logic [7:0] R2_LEAD      = 8'h81;
    localparam logic [7:0] R2_LEAD_MAX  = 8'hA0;
    localparam logic [7:0] R2_GAP       = 8'h3E;
    localparam logic [7:0] R3_LEAD      = 8'hAA;
    localparam logic [7:0] R3_TRAIL_MAX = 8'hA0;
    localparam int         R1_STRIDE    = 94;
    localparam int         R2_STRIDE    = 190;
    localparam int         R2_BASE      = 6768;
    localparam int         R3_STRIDE    = 96;
    localparam int         R3_BASE      = 12848;

    localparam logic KIND_CODE  = 1'b0;
    localparam logic KIND_GLYPH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADDR,
        ST_READ,
        ST_LATCH,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic                load_code;
        logic                send_addr;
        logic                mem_we;
        logic [GLYPH_AW-1:0] waddr;
        logic                mem_re;
        logic                tile_we;
        logic                send_col;
        logic [1:0]          blk;
        logic [2:0]          idx;
        logic                last;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic map_ok;
    } status_t;

endpackage

`default_nettype wire

[rtl/core/gbgcr_ctrl.sv]
`default_nettype none

module gbgcr_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    input  wire logic              s_tuser,
    output logic                   s_tready,
    input  wire gbgcr_pkg::status_t status,
    output gbgcr_pkg::cmd_t        cmd
);
    import gbgcr_pkg::*;

    state_t              state_reg, state_next;
    logic [GLYPH_AW-1:0] cnt_reg, cnt_next;
    logic                valid_reg, valid_next;
    logic [1:0]          blk_reg, blk_next;
    logic [2:0]          idx_reg, idx_next;
    logic                accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
            blk_reg   <= '0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
            blk_reg   <= blk_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && s_tuser == KIND_CODE) begin
                    state_next = ST_ADDR;
                end else if (accept && valid_reg && (&cnt_reg)) begin
                    state_next = ST_READ;
                end
            end
            ST_ADDR: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ: state_next = ST_LATCH;
            ST_LATCH: begin
                state_next = (&idx_reg) ? ST_EMIT : ST_READ;
            end
            ST_EMIT: begin
                if (status.out_free && (&idx_reg)) begin
                    state_next = (&blk_reg) ? ST_IDLE : ST_READ;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // byte count, code valid and tile walk counters
    always_comb begin
        cnt_next   = cnt_reg;
        valid_next = valid_reg;
        blk_next   = blk_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && s_tuser == KIND_CODE) begin
                    cnt_next   = '0;
                    valid_next = status.map_ok;
                end else if (accept && valid_reg) begin
                    cnt_next = cnt_reg + GLYPH_AW'(1);
                    blk_next = '0;
                    idx_next = '0;
                end
            end
            ST_LATCH: idx_next = idx_reg + 3'd1;
            ST_EMIT: begin
                if (status.out_free) begin
                    idx_next = idx_reg + 3'd1;
                    if (&idx_reg) begin
                        blk_next = blk_reg + 2'd1;
                        if (&blk_reg) begin
                            valid_next = 1'b0;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        cmd           = '0;
        cmd.waddr     = cnt_reg;
        cmd.blk       = blk_reg;
        cmd.idx       = idx_reg;
        cmd.last      = (&blk_reg) && (&idx_reg);
        unique case (state_reg)
            ST_IDLE: begin
                cmd.load_code = accept && s_tuser == KIND_CODE;
                cmd.mem_we    = accept && s_tuser == KIND_GLYPH && valid_reg;
            end
            ST_ADDR:  cmd.send_addr = status.out_free;
            ST_READ:  cmd.mem_re    = 1'b1;
            ST_LATCH: cmd.tile_we   = 1'b1;
            ST_EMIT:  cmd.send_col  = status.out_free;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/gbgcr_dp.sv]
`default_nettype none

module gbgcr_dp (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic [gbgcr_pkg::IN_W-1:0]     s_tdata,
    input  wire gbgcr_pkg::cmd_t                cmd,
    output gbgcr_pkg::status_t                  status,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [gbgcr_pkg::OUT_W-1:0]         m_tdata,
    output logic                                m_tuser,
    output logic                                m_tlast
);
    import gbgcr_pkg::*;

    logic [7:0] q, w, in_col, in_byte;
    logic [5:0] in_row;

    assign q       = s_tdata[7:0];
    assign w       = s_tdata[15:8];
    assign in_col  = s_tdata[23:16];
    assign in_row  = s_tdata[29:24];
    assign in_byte = s_tdata[37:30];

    // code to glyph offset
    logic [7:0]       t2;
    logic [OFF_W-1:0] off1, off2, off3, off;
    logic             ok;

    assign t2   = w - TRAIL_MIN;
    assign off1 = OFF_W'(q - R1_LEAD) * OFF_W'(R1_STRIDE) + OFF_W'(w - R1_TRAIL);
    assign off2 = OFF_W'(q - R2_LEAD) * OFF_W'(R2_STRIDE) + OFF_W'(t2) + OFF_W'(R2_BASE)
                  - ((t2 > R2_GAP) ? OFF_W'(1) : OFF_W'(0));
    assign off3 = OFF_W'(q - R3_LEAD) * OFF_W'(R3_STRIDE) + OFF_W'(t2) + OFF_W'(R3_BASE);

    always_comb begin
        ok  = 1'b1;
        off = '0;
        priority if (q <= LEAD_MIN || w < TRAIL_MIN) begin
            ok = 1'b0;
        end else if (q >= R1_LEAD && w >= R1_TRAIL) begin
            off = off1;
        end else if (q <= R2_LEAD_MAX) begin
            off = off2;
        end else if (q >= R3_LEAD && w <= R3_TRAIL_MAX) begin
            off = off3;
        end else begin
            ok = 1'b0;
        end
    end

    logic [ADDR_W-1:0] pend_addr_reg;
    logic              pend_err_reg;
    logic [7:0]        col_base_reg;
    logic [5:0]        row_base_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_code) begin
            pend_addr_reg <= ok ? {off, 5'b0} : '0;
            pend_err_reg  <= !ok;
            col_base_reg  <= in_col;
            row_base_reg  <= in_row;
        end
    end

    // glyph store and 8x8 tile
    logic [7:0] mem [GLYPH_BYTES];
    logic [7:0] rd_data_reg;
    logic [7:0] tile_reg [8];

    always_ff @(posedge aclk) begin
        if (cmd.mem_we) begin
            mem[cmd.waddr] <= in_byte;
        end
        if (cmd.mem_re) begin
            rd_data_reg <= mem[{cmd.blk[1], cmd.idx, cmd.blk[0]}];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.tile_we) begin
            tile_reg[cmd.idx] <= rd_data_reg;
        end
    end

    logic [7:0] col_bits;
    logic [8:0] col;
    logic [6:0] row;
    logic       off_scr;

    always_comb begin
        for (int r = 0; r < 8; r++) begin
            col_bits[r] = tile_reg[r][~cmd.idx];
        end
    end

    assign col     = {1'b0, col_base_reg} + {5'b0, cmd.blk[0], cmd.idx};
    assign row     = {1'b0, row_base_reg} + {3'b000, cmd.blk[1], 3'b000};
    assign off_scr = (col >= 9'(PANEL_COLUMNS)) || (row >= 7'(PANEL_ROWS));

    // output register
    logic        valid_reg;
    logic        kind_reg;
    logic [19:0] addr_reg;
    logic        err_reg;
    logic [1:0]  cs_reg;
    logic [5:0]  ccol_reg;
    logic [2:0]  page_reg;
    logic [7:0]  data_reg;
    logic        offs_reg;
    logic        last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.send_addr || cmd.send_col) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.send_addr) begin
            kind_reg <= 1'b0;
            addr_reg <= pend_addr_reg;
            err_reg  <= pend_err_reg;
            cs_reg   <= '0;
            ccol_reg <= '0;
            page_reg <= '0;
            data_reg <= '0;
            offs_reg <= 1'b0;
            last_reg <= 1'b0;
        end else if (cmd.send_col) begin
            kind_reg <= 1'b1;
            addr_reg <= '0;
            err_reg  <= 1'b0;
            cs_reg   <= col[CHIP_BITS+1:CHIP_BITS];
            ccol_reg <= col[CHIP_BITS-1:0];
            page_reg <= row[5:3];
            data_reg <= col_bits;
            offs_reg <= off_scr;
            last_reg <= cmd.last;
        end
    end

    assign status = '{out_free: !valid_reg || m_tready, map_ok: ok};

    assign m_tvalid = valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {7'b0, offs_reg, data_reg, page_reg, ccol_reg, cs_reg, err_reg, addr_reg};

endmodule

`default_nettype wire

[rtl/core/gb_glyph_column_renderer.sv]
`default_nettype none

// GB 16x16 glyph renderer for a column-addressed multi-chip LCD panel. A code
// transaction (tuser = 0) maps the two-byte GB code to a font byte address and
// returns one address result, flagging unmapped codes. Each following glyph
// transaction (tuser = 1) stores one font byte. The 32nd byte starts
// rendering: the four 8x8 blocks are read row by row from the glyph store
// (read then latch for each row) and emitted as 8 column writes each, and
// the input stays not ready meanwhile. Glyph bytes with no valid code are
// dropped. The glyph store needs no clearing after reset.
module gb_glyph_column_renderer (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // code_high[7:0], code_low[15:8], start_column[23:16], start_row[29:24],
    // glyph_byte[37:30]
    input  wire logic [gbgcr_pkg::IN_W-1:0]  s_tdata,
    // kind[0]
    input  wire logic                        s_tuser,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // font_address[19:0], code_error[20], chip_select[22:21],
    // chip_column[28:23], page[31:29], column_data[39:32], off_screen[40]
    output logic [gbgcr_pkg::OUT_W-1:0]      m_tdata,
    // result_kind[0]
    output logic                             m_tuser,
    output logic                             m_tlast
);
    import gbgcr_pkg::*;

    cmd_t    cmd;
    status_t status;

    gbgcr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gbgcr_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
